// ===== hw/rtl/mtkd_pkg.sv =====
`timescale 1ns / 1ps
package mtkd_pkg;

  // Twister geometry and constants
  localparam int unsigned TwisterWords = 624;
  localparam int unsigned TwShift      = 397;
  localparam logic [31:0] TwMatrix     = 32'h9908_B0DF;
  localparam logic [31:0] TwUpper      = 32'h8000_0000;
  localparam logic [31:0] TwLower      = 32'h7FFF_FFFF;
  localparam logic [31:0] SeedMult     = 32'd1812433253;
  localparam logic [31:0] SeedOffset   = 32'd6;

  // Tempering masks
  localparam logic [31:0] TemperB      = 32'h9D2C_5680;
  localparam logic [31:0] TemperC      = 32'hEFC6_0000;

  // Byte key schedule
  localparam logic [7:0]  KeyInit      = 8'hC5;
  localparam logic [7:0]  StepInit     = 8'h83;
  localparam logic [7:0]  StepAdd      = 8'h53;

  localparam int unsigned HdrSizeW     = 24;

  // Input beat action codes
  localparam logic ActStart = 1'b0;
  localparam logic ActData  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TWIST,
    ST_SEED
  } state_e;

  // Words fed to the twist unit
  typedef struct packed {
    logic [31:0] cur_word;
    logic [31:0] next_word;
    logic [31:0] far_word;
  } twist_in_t;

  // Results of the twist unit
  typedef struct packed {
    logic [31:0] new_word;
    logic [7:0]  key_byte;
  } twist_out_t;

endpackage

// ===== hw/rtl/mtkd_intf.sv =====
`timescale 1ns / 1ps
interface mtkd_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] cipher_byte;

  modport source (output valid, output action, output cipher_byte, input ready);
  modport sink   (input valid, input action, input cipher_byte, output ready);
endinterface

interface mtkd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] plain_byte;

  modport source (output valid, output plain_byte, input ready);
  modport sink   (input valid, input plain_byte, output ready);
endinterface

// ===== hw/rtl/mtkd_ram.sv =====
`timescale 1ns / 1ps
module mtkd_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 624,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_a_i,
  input  logic [AddrW-1:0] raddr_b_i,
  output logic [Width-1:0] rdata_a_o,
  output logic [Width-1:0] rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_a_q;
  logic [Width-1:0] rdata_b_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Two registered read ports
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ===== hw/rtl/mtkd_twist.sv =====
`timescale 1ns / 1ps
module mtkd_twist (
  input  mtkd_pkg::twist_in_t  twist_i,
  output mtkd_pkg::twist_out_t twist_o
);
  import mtkd_pkg::*;

  logic [31:0] y;
  logic [31:0] new_word;
  logic [31:0] t0;
  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] t3;

  // Regenerate one word from its neighbor and the far tap
  always_comb begin
    y        = (twist_i.cur_word & TwUpper) | (twist_i.next_word & TwLower);
    new_word = twist_i.far_word ^ (y >> 1) ^ (y[0] ? TwMatrix : 32'd0);
  end

  // Temper the new word
  always_comb begin
    t0 = new_word ^ (new_word >> 11);
    t1 = t0 ^ ((t0 << 7) & TemperB);
    t2 = t1 ^ ((t1 << 15) & TemperC);
    t3 = t2 ^ (t2 >> 18);
  end

  assign twist_o.new_word = new_word;
  assign twist_o.key_byte = t3[7:0];

endmodule

// ===== hw/rtl/mt_keystream_header_decrypt.sv =====
`timescale 1ns / 1ps
// Header keystream decryptor.
// Input channel in_i (sink): action 0 is a start beat, action 1 carries a
// cipher byte. Output channel out_o (source) delivers one plain byte per data
// beat and nothing for a start beat. Configuration: header_size is written
// through cfg_we_i / cfg_wdata_i; the user must write it only while the block
// is idle, which the block does not enforce. It is used as the twister seed
// (plus six) at the next start beat. A data beat is accepted, the twister
// RAM returns the next word and the far tap in the next cycle, then in the
// twist state, once the output register is free, the word is regenerated,
// written back and its tempered byte loads the output register. Due to this
// read-modify-write, no new data beat is accepted until the previous one has
// left the twist state. A start beat writes word zero as it is accepted and
// the other 623 words one per cycle through the seed multiplier; in_i.ready
// stays low until the last word is written. When out_o stalls, the finished
// byte holds in the output register; the next data beat is still accepted
// and waits in the twist state until the output register frees up.
// Reset clears the control state, the byte key (0xC5), its step (0x83) and
// the twister index. Twister words hold nothing useful until a start beat.
module mt_keystream_header_decrypt #(
  parameter int unsigned TWISTER_WORDS = mtkd_pkg::TwisterWords
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mtkd_pkg::HdrSizeW-1:0]  cfg_wdata_i,
  mtkd_in_if.sink                        in_i,
  mtkd_out_if.source                     out_o
);
  import mtkd_pkg::*;

  localparam int unsigned IdxW = $clog2(TWISTER_WORDS);
  localparam logic [IdxW-1:0] LastIdx  = IdxW'(TWISTER_WORDS - 1);
  localparam logic [IdxW:0]   ShiftIdx = (IdxW + 1)'(TwShift % TWISTER_WORDS);
  localparam logic [IdxW:0]   DepthIdx = (IdxW + 1)'(TWISTER_WORDS);

  state_e state_q, state_d;

  logic [HdrSizeW-1:0] hdr_size_q;
  logic [IdxW-1:0]     idx_q, idx_d;
  logic [IdxW-1:0]     cnt_q, cnt_d;
  logic [31:0]         prev_q, prev_d;
  logic [31:0]         cur_q, cur_d;
  logic [7:0]          key_q, key_d;
  logic [7:0]          step_q, step_d;
  logic [7:0]          cipher_q;
  logic                out_valid_q, out_valid_d;
  logic [7:0]          out_byte_q, out_byte_d;

  logic                in_fire;
  logic                out_free;
  logic                twist_done;
  logic [31:0]         seed_word;
  logic [31:0]         seed_mix;
  logic [31:0]         seed_next;
  logic [IdxW-1:0]     idx_next1;
  logic [IdxW:0]       far_sum;
  logic [IdxW-1:0]     idx_far;

  logic                ram_we;
  logic [IdxW-1:0]     ram_waddr;
  logic [31:0]         ram_wdata;
  logic                ram_re;
  logic [31:0]         rd_next;
  logic [31:0]         rd_far;

  twist_in_t           twist_in;
  twist_out_t          twist_out;

  // Handshake terms
  assign in_i.ready  = (state_q == ST_IDLE);
  assign in_fire     = in_i.valid && in_i.ready;
  assign out_free    = !out_valid_q || out_o.ready;
  assign twist_done  = (state_q == ST_TWIST) && out_free;

  // Seed arithmetic
  assign seed_word = {{(32 - HdrSizeW){1'b0}}, hdr_size_q} + SeedOffset;
  assign seed_mix  = prev_q ^ (prev_q >> 30);
  assign seed_next = 32'(SeedMult * seed_mix) + {{(32 - IdxW){1'b0}}, cnt_q};

  // Neighbor and far tap addresses, modulo the twister depth
  assign idx_next1 = (idx_q == LastIdx) ? '0 : idx_q + 1'b1;
  assign far_sum   = {1'b0, idx_q} + ShiftIdx;
  assign idx_far   = (far_sum >= DepthIdx) ? IdxW'(far_sum - DepthIdx) : far_sum[IdxW-1:0];

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = (in_i.action == ActStart) ? ST_SEED : ST_TWIST;
        end
      end
      ST_TWIST: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_SEED: begin
        if (cnt_q == LastIdx) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // RAM access per state
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_q;
    ram_wdata = twist_out.new_word;
    ram_re    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire && in_i.action == ActStart) begin
          ram_we    = 1'b1;
          ram_waddr = '0;
          ram_wdata = seed_word;
        end
        ram_re = in_fire && (in_i.action == ActData);
      end
      ST_TWIST: begin
        ram_we = out_free;
      end
      ST_SEED: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_q;
        ram_wdata = seed_next;
      end
      default: ;
    endcase
  end

  // Datapath register updates
  always_comb begin
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    prev_d      = prev_q;
    cur_d       = cur_q;
    key_d       = key_q;
    step_d      = step_q;
    out_byte_d  = out_byte_q;
    out_valid_d = out_valid_q && !out_o.ready;
    if (in_fire && in_i.action == ActStart) begin
      idx_d  = '0;
      cnt_d  = IdxW'(1);
      prev_d = seed_word;
      cur_d  = seed_word;
      key_d  = KeyInit;
      step_d = StepInit;
    end
    if (state_q == ST_SEED) begin
      cnt_d  = cnt_q + 1'b1;
      prev_d = seed_next;
    end
    if (twist_done) begin
      idx_d       = idx_next1;
      cur_d       = rd_next;
      key_d       = key_q + step_q;
      step_d      = step_q + StepAdd;
      out_byte_d  = cipher_q ^ twist_out.key_byte ^ key_q;
      out_valid_d = 1'b1;
    end
  end

  // Control and key state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      hdr_size_q  <= '0;
      idx_q       <= '0;
      cnt_q       <= '0;
      key_q       <= KeyInit;
      step_q      <= StepInit;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      cnt_q       <= cnt_d;
      key_q       <= key_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        hdr_size_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    prev_q     <= prev_d;
    cur_q      <= cur_d;
    out_byte_q <= out_byte_d;
    if (in_fire) begin
      cipher_q <= in_i.cipher_byte;
    end
  end

  // Twister word store
  mtkd_ram #(
    .Width (32),
    .Depth (TWISTER_WORDS)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .re_i      (ram_re),
    .raddr_a_i (idx_next1),
    .raddr_b_i (idx_far),
    .rdata_a_o (rd_next),
    .rdata_b_o (rd_far)
  );

  // Regenerate and temper
  assign twist_in.cur_word  = cur_q;
  assign twist_in.next_word = rd_next;
  assign twist_in.far_word  = rd_far;

  mtkd_twist u_twist (
    .twist_i (twist_in),
    .twist_o (twist_out)
  );

  assign out_o.valid      = out_valid_q;
  assign out_o.plain_byte = out_byte_q;

  // A data beat moves to the twist step, a start beat to seeding
  a_data_to_twist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_i.action == ActData) |=> (state_q == ST_TWIST))
    else $error("data beat did not enter twist step");

  a_start_to_seed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_i.action == ActStart) |=> (state_q == ST_SEED && cnt_q == IdxW'(1)))
    else $error("start beat did not begin seeding at word one");

  // A finished twist always presents its byte
  a_twist_loads_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    twist_done |=> out_valid_q)
    else $error("twist result not loaded into output register");

  // The twister index stays within the word store
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, idx_q} < DepthIdx)
    else $error("twister index out of range");

  // Write-back never lands on a word read for the same beat
  a_no_rmw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TWIST) |-> (idx_q != idx_next1 && idx_q != idx_far))
    else $error("twist write-back overlaps its own reads");

endmodule
